### rtl/efr_pkg.sv
// Shared types, constants and register indexes for the escaped frame receiver.
// Used by every module of the block except efr_ram; depends on nothing else.
`timescale 1ns / 1ps

package efr_pkg;

  // Byte and field widths.
  localparam int unsigned ByteW    = 8;
  localparam int unsigned LenW     = 6;
  localparam int unsigned CfgIdxW  = 2;

  // Default frame buffer depth (legal range 2 to 64).
  localparam int unsigned BufferDepthDef = 64;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_FLAG_VALUE   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ESCAPE_VALUE = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ESCAPE_MASK  = 2'd2;

  // Register reset values.
  localparam logic [ByteW-1:0] FLAG_VALUE_RST   = 8'd126;
  localparam logic [ByteW-1:0] ESCAPE_VALUE_RST = 8'd125;
  localparam logic [ByteW-1:0] ESCAPE_MASK_RST  = 8'd32;

  typedef struct packed {
    logic [ByteW-1:0] flag_value;
    logic [ByteW-1:0] escape_value;
    logic [ByteW-1:0] escape_xor_mask;
  } cfg_t;

  // Request from the frame controller to the readout engine.
  typedef struct packed {
    logic            start;
    logic [LenW-1:0] len;
  } drain_req_t;

  typedef enum logic [1:0] {
    RD_IDLE,
    RD_LOAD,
    RD_OUT
  } rd_state_e;

endpackage

### rtl/efr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependency.
`timescale 1ns / 1ps

module efr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/efr_frame_ctl.sv
// Receive side: escape removal, frame store writes, running check sum and frame close.
// Depends on efr_pkg.
`timescale 1ns / 1ps

module efr_frame_ctl #(
  parameter int unsigned BufferDepth = efr_pkg::BufferDepthDef,
  localparam int unsigned AddrW = (BufferDepth > 1) ? $clog2(BufferDepth) : 1,
  localparam int unsigned CntW  = $clog2(BufferDepth + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  efr_pkg::cfg_t            cfg_i,
  input  logic                     byte_xfer_i,
  input  logic [efr_pkg::ByteW-1:0] rx_byte_i,
  output logic                     we_o,
  output logic [AddrW-1:0]         waddr_o,
  output logic [efr_pkg::ByteW-1:0] wdata_o,
  output efr_pkg::drain_req_t      drain_o
);

  logic [CntW-1:0]           count_q, count_d;
  logic                      esc_q, esc_d;
  logic                      ovf_q, ovf_d;
  // Sum of all stored bytes except the most recent one, and that most recent byte.
  logic [efr_pkg::ByteW-1:0] sum_q, sum_d;
  logic [efr_pkg::ByteW-1:0] last_q, last_d;

  logic                      is_flag, is_esc;
  logic [efr_pkg::ByteW-1:0] data_byte;
  logic                      has_room;

  assign is_flag   = (rx_byte_i == cfg_i.flag_value);
  assign is_esc    = !is_flag && (rx_byte_i == cfg_i.escape_value);
  assign data_byte = esc_q ? (rx_byte_i ^ cfg_i.escape_xor_mask) : rx_byte_i;
  assign has_room  = (count_q < CntW'(BufferDepth));

  always_comb begin
    count_d       = count_q;
    esc_d         = esc_q;
    ovf_d         = ovf_q;
    sum_d         = sum_q;
    last_d        = last_q;
    we_o          = 1'b0;
    drain_o.start = 1'b0;
    drain_o.len   = efr_pkg::LenW'(count_q - CntW'(1));
    if (byte_xfer_i) begin
      if (is_flag) begin
        drain_o.start = !ovf_q && (count_q > CntW'(1)) && (sum_q == last_q);
        count_d       = '0;
        esc_d         = 1'b0;
        ovf_d         = 1'b0;
        sum_d         = '0;
        last_d        = '0;
      end else if (is_esc) begin
        esc_d = 1'b1;
      end else begin
        esc_d = 1'b0;
        if (has_room) begin
          we_o    = 1'b1;
          count_d = count_q + CntW'(1);
          last_d  = data_byte;
          if (count_q != '0) begin
            sum_d = sum_q + last_q;
          end
        end else begin
          ovf_d = 1'b1;
        end
      end
    end
  end

  assign waddr_o = AddrW'(count_q);
  assign wdata_o = data_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      esc_q   <= 1'b0;
      ovf_q   <= 1'b0;
      sum_q   <= '0;
      last_q  <= '0;
    end else begin
      count_q <= count_d;
      esc_q   <= esc_d;
      ovf_q   <= ovf_d;
      sum_q   <= sum_d;
      last_q  <= last_d;
    end
  end

endmodule

### rtl/efr_readout.sv
// Readout engine: walks the frame store after a passing frame and drives the result register.
// Depends on efr_pkg.
`timescale 1ns / 1ps

module efr_readout #(
  parameter int unsigned BufferDepth = efr_pkg::BufferDepthDef,
  localparam int unsigned AddrW = (BufferDepth > 1) ? $clog2(BufferDepth) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  efr_pkg::drain_req_t       drain_i,
  output logic                      re_o,
  output logic [AddrW-1:0]          raddr_o,
  input  logic [efr_pkg::ByteW-1:0] rdata_i,
  output logic                      idle_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [efr_pkg::ByteW-1:0] payload_byte_o,
  output logic                      frame_end_o,
  output logic [efr_pkg::LenW-1:0]  payload_length_o
);

  efr_pkg::rd_state_e state_q, state_d;
  logic [AddrW-1:0]          ptr_q, ptr_d;
  logic [efr_pkg::LenW-1:0]  len_q, len_d;
  logic [efr_pkg::ByteW-1:0] data_q;
  logic                      end_q;
  logic                      at_last;

  assign at_last = (efr_pkg::LenW'(ptr_q) == (len_q - efr_pkg::LenW'(1)));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      efr_pkg::RD_IDLE: begin
        if (drain_i.start) begin
          state_d = efr_pkg::RD_LOAD;
        end
      end
      efr_pkg::RD_LOAD: begin
        state_d = efr_pkg::RD_OUT;
      end
      efr_pkg::RD_OUT: begin
        if (out_ready_i) begin
          state_d = end_q ? efr_pkg::RD_IDLE : efr_pkg::RD_LOAD;
        end
      end
      default: begin
        state_d = efr_pkg::RD_IDLE;
      end
    endcase
  end

  // Outputs and datapath controls.
  always_comb begin
    re_o        = 1'b0;
    raddr_o     = ptr_q;
    ptr_d       = ptr_q;
    len_d       = len_q;
    idle_o      = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      efr_pkg::RD_IDLE: begin
        idle_o = 1'b1;
        if (drain_i.start) begin
          re_o    = 1'b1;
          raddr_o = '0;
          ptr_d   = '0;
          len_d   = drain_i.len;
        end
      end
      efr_pkg::RD_LOAD: begin
      end
      efr_pkg::RD_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i && !end_q) begin
          re_o    = 1'b1;
          raddr_o = ptr_q + AddrW'(1);
          ptr_d   = ptr_q + AddrW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= efr_pkg::RD_IDLE;
      ptr_q   <= '0;
      len_q   <= '0;
      end_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      len_q   <= len_d;
      if (state_q == efr_pkg::RD_LOAD) begin
        end_q <= at_last;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == efr_pkg::RD_LOAD) begin
      data_q <= rdata_i;
    end
  end

  assign payload_byte_o   = data_q;
  assign frame_end_o      = end_q;
  assign payload_length_o = len_q;

endmodule

### rtl/escaped_frame_receiver_sum_check_unit.sv
// Top level of the escaped frame receiver with additive sum check.
// Depends on efr_pkg, efr_ram, efr_frame_ctl and efr_readout.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                    Payload
// rx        in         rx_valid_i / rx_ready_o      rx_byte_i
// out       out        out_valid_o / out_ready_i    payload_byte_o, frame_end_o,
//                                                   payload_length_o
// cfg       in         cfg_we_i (no wait)           cfg_idx_i, cfg_wdata_i
//
// An ordinary, escape or failing flag byte is taken without holding off the
// input, so the next byte may follow it directly.
// A flag byte that closes a passing frame starts a readout in which each payload
// byte goes through the frame store read, then the result register, and the
// receiver stays busy until the last byte has been taken at the output.
// While the readout runs rx_ready_o is low; the result register holds its
// byte until out_ready_i takes it.
// Reset clears the control state and loads the register defaults. The frame
// store needs no clearing pass, since only entries written in the current
// frame are ever read.

module escaped_frame_receiver_sum_check_unit #(
  parameter int unsigned BufferDepth = efr_pkg::BufferDepthDef,
  localparam int unsigned AddrW = (BufferDepth > 1) ? $clog2(BufferDepth) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Received link bytes.
  input  logic                        rx_valid_i,
  output logic                        rx_ready_o,
  input  logic [efr_pkg::ByteW-1:0]   rx_byte_i,
  // Payload bytes of frames that passed the check.
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [efr_pkg::ByteW-1:0]   payload_byte_o,
  output logic                        frame_end_o,
  output logic [efr_pkg::LenW-1:0]    payload_length_o,
  // Configuration write port.
  input  logic                        cfg_we_i,
  input  logic [efr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [efr_pkg::ByteW-1:0]   cfg_wdata_i
);

  efr_pkg::cfg_t cfg_q, cfg_d;

  // Register write decode. Index three is not a register and is dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        efr_pkg::CFG_FLAG_VALUE:   cfg_d.flag_value      = cfg_wdata_i;
        efr_pkg::CFG_ESCAPE_VALUE: cfg_d.escape_value    = cfg_wdata_i;
        efr_pkg::CFG_ESCAPE_MASK:  cfg_d.escape_xor_mask = cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flag_value      <= efr_pkg::FLAG_VALUE_RST;
      cfg_q.escape_value    <= efr_pkg::ESCAPE_VALUE_RST;
      cfg_q.escape_xor_mask <= efr_pkg::ESCAPE_MASK_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  logic                      rx_xfer;
  logic                      rd_idle;
  logic                      ram_we;
  logic [AddrW-1:0]          ram_waddr;
  logic [efr_pkg::ByteW-1:0] ram_wdata;
  logic                      ram_re;
  logic [AddrW-1:0]          ram_raddr;
  logic [efr_pkg::ByteW-1:0] ram_rdata;
  efr_pkg::drain_req_t       drain;

  // Bytes are taken only while no readout is in progress.
  assign rx_ready_o = rd_idle;
  assign rx_xfer    = rx_valid_i && rx_ready_o;

  // The frame controller keeps the running sum as bytes arrive, so the close
  // decision is made in the flag transfer cycle. Store writes and reads never
  // overlap: the flag writes nothing; other reads run with input held off.
  efr_frame_ctl #(
    .BufferDepth (BufferDepth)
  ) u_frame_ctl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .byte_xfer_i (rx_xfer),
    .rx_byte_i   (rx_byte_i),
    .we_o        (ram_we),
    .waddr_o     (ram_waddr),
    .wdata_o     (ram_wdata),
    .drain_o     (drain)
  );

  efr_ram #(
    .Width (efr_pkg::ByteW),
    .Depth (BufferDepth)
  ) u_frame_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  efr_readout #(
    .BufferDepth (BufferDepth)
  ) u_readout (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .drain_i          (drain),
    .re_o             (ram_re),
    .raddr_o          (ram_raddr),
    .rdata_i          (ram_rdata),
    .idle_o           (rd_idle),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .payload_byte_o   (payload_byte_o),
    .frame_end_o      (frame_end_o),
    .payload_length_o (payload_length_o)
  );

`ifndef SYNTHESIS
  // Input is never taken while a result is on offer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rx_ready_o && out_valid_o))
    else $error("input ready while a result is pending");

  // A passing frame close starts the readout on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain.start |=> !rx_ready_o)
    else $error("readout did not start after a passing frame");

  // Delivery of the last byte of a frame returns the receiver to input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && frame_end_o) |=> rx_ready_o)
    else $error("receiver not ready after the end of a frame");

  // The frame store is never written while it is being read out.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && !rd_idle))
    else $error("frame store written during readout");
`endif

endmodule

### tb/sv/efr_payload_checker.sv
// Payload checker for the escaped frame receiver: watches the rx, out and
// configuration ports, predicts the delivered payload beats and compares them.
// Depends on efr_pkg for widths, register indexes and reset values.
`timescale 1ns / 1ps

module efr_payload_checker #(
  parameter int unsigned Depth = efr_pkg::BufferDepthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rx_valid_i,
  input  logic                        rx_ready_o,
  input  logic [efr_pkg::ByteW-1:0]   rx_byte_i,
  input  logic                        out_valid_o,
  input  logic                        out_ready_i,
  input  logic [efr_pkg::ByteW-1:0]   payload_byte_o,
  input  logic                        frame_end_o,
  input  logic [efr_pkg::LenW-1:0]    payload_length_o,
  input  logic                        cfg_we_i,
  input  logic [efr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [efr_pkg::ByteW-1:0]   cfg_wdata_i,
  output int unsigned                 mismatch_count_o,
  output int unsigned                 owed_beats_o
);

  localparam int unsigned ByteW = efr_pkg::ByteW;
  localparam int unsigned LenW  = efr_pkg::LenW;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
    logic [LenW-1:0]  len;
  } payload_beat_t;

  payload_beat_t    owed_beats [$];
  efr_pkg::cfg_t    link_cfg;
  logic [ByteW-1:0] frame_buf [Depth];
  int unsigned      held_count;
  logic             escape_armed;
  logic             overrun;

  // Unstuffs one received byte; a closing flag of a frame whose trailing
  // byte matches the wrapping sum of the others owes its payload beats.
  task automatic deframe_byte(input logic [ByteW-1:0] c);
    int unsigned      plen;
    int unsigned      i;
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] b;
    if (c == link_cfg.flag_value) begin
      if (!overrun && held_count > 1 && held_count <= Depth) begin
        plen = held_count - 1;
        sum = '0;
        for (i = 0; i < plen; i++) sum += frame_buf[i];
        if (sum == frame_buf[plen]) begin
          for (i = 0; i < plen; i++) begin
            owed_beats.push_back('{data: frame_buf[i], last: (i == plen - 1),
                                   len: LenW'(plen)});
          end
        end
      end
      held_count = 0;
      escape_armed = 1'b0;
      overrun = 1'b0;
    end else if (c == link_cfg.escape_value) begin
      escape_armed = 1'b1;
    end else begin
      b = escape_armed ? (c ^ link_cfg.escape_xor_mask) : c;
      escape_armed = 1'b0;
      if (held_count < Depth) begin
        frame_buf[held_count] = b;
        held_count++;
      end else begin
        overrun = 1'b1;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    payload_beat_t want;
    if (!rst_ni) begin
      link_cfg = '{flag_value: efr_pkg::FLAG_VALUE_RST,
                   escape_value: efr_pkg::ESCAPE_VALUE_RST,
                   escape_xor_mask: efr_pkg::ESCAPE_MASK_RST};
      held_count = 0;
      escape_armed = 1'b0;
      overrun = 1'b0;
      owed_beats.delete();
      mismatch_count_o = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (owed_beats.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual byte %02h end %0b len %0d",
                   $time, payload_byte_o, frame_end_o, payload_length_o);
          mismatch_count_o++;
        end else begin
          want = owed_beats.pop_front();
          if (payload_byte_o !== want.data) begin
            $display("%0t: payload_byte expected %02h, actual %02h",
                     $time, want.data, payload_byte_o);
            mismatch_count_o++;
          end
          if (frame_end_o !== want.last) begin
            $display("%0t: frame_end expected %0b, actual %0b",
                     $time, want.last, frame_end_o);
            mismatch_count_o++;
          end
          if (payload_length_o !== want.len) begin
            $display("%0t: payload_length expected %0d, actual %0d",
                     $time, want.len, payload_length_o);
            mismatch_count_o++;
          end
        end
      end
      if (rx_valid_i && rx_ready_o) deframe_byte(rx_byte_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          efr_pkg::CFG_FLAG_VALUE:   link_cfg.flag_value = cfg_wdata_i;
          efr_pkg::CFG_ESCAPE_VALUE: link_cfg.escape_value = cfg_wdata_i;
          efr_pkg::CFG_ESCAPE_MASK:  link_cfg.escape_xor_mask = cfg_wdata_i;
          default: ;
        endcase
      end
    end
    owed_beats_o = owed_beats.size();
  end

endmodule

### tb/sv/escaped_frame_receiver_sum_check_unit_tb.sv
// Testbench top for the escaped frame receiver: builds stuffed link traffic,
// programs the registers between phases and reports the verdict.
// Depends on efr_pkg, efr_payload_checker and the escaped_frame_receiver_sum_check_unit RTL.
`timescale 1ns / 1ps

module escaped_frame_receiver_sum_check_unit_tb;

  localparam int unsigned ByteW   = efr_pkg::ByteW;
  localparam int unsigned LenW    = efr_pkg::LenW;
  localparam int unsigned CfgIdxW = efr_pkg::CfgIdxW;
  localparam int unsigned Depth   = efr_pkg::BufferDepthDef;
  // No register sits at the last index of the port; writes there must vanish.
  localparam logic [CfgIdxW-1:0] CFG_UNMAPPED = 2'd3;
  // Cycles without any transfer or register write before the run is declared hung.
  // The slowest legal stretch is a sender gap or a receiver stall plus a readout
  // step, so this leaves a wide margin.
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned RandomBytes = 40;

  typedef enum int {
    FR_GOOD,
    FR_BADSUM,
    FR_SHORT,
    FR_OVERFLOW,
    FR_NOISE
  } frame_kind_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               rx_valid_i = 1'b0;
  logic               rx_ready_o;
  logic [ByteW-1:0]   rx_byte_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [ByteW-1:0]   payload_byte_o;
  logic               frame_end_o;
  logic [LenW-1:0]    payload_length_o;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = efr_pkg::CFG_FLAG_VALUE;
  logic [ByteW-1:0]   cfg_wdata_i = '0;

  int unsigned mismatch_count;
  int unsigned owed_count;
  int unsigned quiet_cycles = 0;
  int unsigned bytes_sent = 0;

  // The stimulus keeps its own copy of the programmed registers so that it
  // can stuff the frames it builds the way the block expects them.
  logic [ByteW-1:0] cur_flag = efr_pkg::FLAG_VALUE_RST;
  logic [ByteW-1:0] cur_esc  = efr_pkg::ESCAPE_VALUE_RST;
  logic [ByteW-1:0] cur_mask = efr_pkg::ESCAPE_MASK_RST;

  // When set, the matching side runs without any idle cycles for a phase.
  logic rx_quiet = 1'b0;
  logic out_quiet = 1'b0;

  logic [ByteW-1:0] link_q [$];

  escaped_frame_receiver_sum_check_unit #(.BufferDepth(Depth)) dut (.*);

  efr_payload_checker #(.Depth(Depth)) u_payload_check (
    .*,
    .mismatch_count_o(mismatch_count),
    .owed_beats_o(owed_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Any transfer or register write counts as progress. A run that stops
  // making progress is a hang in the block, and it fails.
  always @(posedge clk_i) begin
    if ((rx_valid_i && rx_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Output side: before every transfer the receiver stalls for a random
  // number of cycles, then holds ready high until a beat is taken.
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = out_quiet ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do begin
        @(posedge clk_i);
      end while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  // A byte can go out escaped only when the escape byte is not swallowed by
  // the flag and the masked value is an ordinary byte.
  function automatic logic can_escape(input logic [ByteW-1:0] b);
    return (cur_esc != cur_flag) && ((b ^ cur_mask) != cur_flag) &&
           ((b ^ cur_mask) != cur_esc);
  endfunction

  function automatic logic encodable(input logic [ByteW-1:0] b);
    return ((b != cur_flag) && (b != cur_esc)) || can_escape(b);
  endfunction

  function automatic logic [ByteW-1:0] pick_encodable();
    logic [ByteW-1:0] b;
    do begin
      b = ByteW'($urandom_range(0, 255));
    end while (!encodable(b));
    return b;
  endfunction

  // Mostly short payloads keep the run quick; a few reach the buffer limit.
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 6);
    if (r < 95) return $urandom_range(7, 20);
    return $urandom_range(21, Depth - 1);
  endfunction

  // Appends one stored byte to the link queue. Flag and escape values must
  // be escaped; other bytes are escaped now and then just to exercise it.
  task automatic stuff_byte(input logic [ByteW-1:0] b);
    if ((b == cur_flag) || (b == cur_esc) || (can_escape(b) && $urandom_range(0, 7) == 0)) begin
      link_q.push_back(cur_esc);
      link_q.push_back(b ^ cur_mask);
    end else begin
      link_q.push_back(b);
    end
  endtask

  // Builds one frame of the given kind under the current registers. Good
  // and corrupted frames carry plen payload bytes and a trailing sum byte.
  task automatic queue_frame(input frame_kind_e kind, input int plen);
    logic [ByteW-1:0] body [$];
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] chk;
    int n;
    if (kind == FR_NOISE) begin
      // Raw bytes with no structure, flags and escapes included.
      n = $urandom_range(1, 8);
      repeat (n) link_q.push_back(ByteW'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 1) link_q.push_back(cur_flag);
    end else begin
      if (kind == FR_OVERFLOW) begin
        n = Depth + 1 + $urandom_range(0, 3);
      end else if (kind == FR_SHORT) begin
        n = $urandom_range(0, 1);
      end else begin
        n = plen;
      end
      repeat (n) body.push_back(pick_encodable());
      if ((kind == FR_GOOD) || (kind == FR_BADSUM)) begin
        // Redraw the first byte until the sum byte itself can be sent.
        do begin
          sum = '0;
          foreach (body[i]) sum += body[i];
          chk = sum;
          if (kind == FR_BADSUM) chk = sum + ByteW'($urandom_range(1, 255));
          if (!encodable(chk)) body[0] = pick_encodable();
        end while (!encodable(chk));
        body.push_back(chk);
      end
      foreach (body[i]) stuff_byte(body[i]);
      link_q.push_back(cur_flag);
    end
  endtask

  // Offers one byte on rx. Called at a falling edge and returns at the
  // falling edge after the transfer, with valid still high so that a
  // back-to-back byte needs no second assignment in the same step.
  task automatic send_rx(input logic [ByteW-1:0] b);
    int unsigned gap;
    gap = rx_quiet ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      rx_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i <= b;
    do begin
      @(posedge clk_i);
    end while (!rx_ready_o);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_link();
    while (link_q.size() > 0) send_rx(link_q.pop_front());
  endtask

  // Drops valid and waits until every owed beat has been taken. The extra
  // cycles cover a closing flag that owes nothing but is still in flight.
  task automatic settle();
    rx_valid_i <= 1'b0;
    while (owed_count != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Writes all three registers and then the unmapped index, which the block
  // must ignore. Only called while the block is idle.
  task automatic program_regs(input logic [ByteW-1:0] flag, input logic [ByteW-1:0] esc,
                              input logic [ByteW-1:0] mask);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= efr_pkg::CFG_FLAG_VALUE;
    cfg_wdata_i <= flag;
    @(negedge clk_i);
    cfg_idx_i <= efr_pkg::CFG_ESCAPE_VALUE;
    cfg_wdata_i <= esc;
    @(negedge clk_i);
    cfg_idx_i <= efr_pkg::CFG_ESCAPE_MASK;
    cfg_wdata_i <= mask;
    @(negedge clk_i);
    cfg_idx_i <= CFG_UNMAPPED;
    cfg_wdata_i <= ByteW'($urandom_range(0, 255));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_flag = flag;
    cur_esc = esc;
    cur_mask = mask;
  endtask

  initial begin
    int unsigned sent_mark;
    int unsigned phase;
    int unsigned frames;
    int r;
    logic [ByteW-1:0] f;
    logic [ByteW-1:0] e;
    logic [ByteW-1:0] m;
    frame_kind_e kind;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Opening traffic under the reset registers (flag 7e, escape 7d, mask 20):
    // an empty frame, a one-byte frame, one-byte payloads of all zeros and
    // all ones, escaped flag and escape values with a doubled escape before
    // the sum byte, a flag that cuts off a pending escape, and a frame whose
    // sum byte does not match.
    link_q = '{8'h7e,
               8'h00, 8'h7e,
               8'h00, 8'h00, 8'h7e,
               8'hff, 8'hff, 8'h7e,
               8'h7d, 8'h5e, 8'h7d, 8'h5d, 8'h7d, 8'h7d, 8'hdb, 8'h7e,
               8'h01, 8'h01, 8'h7d, 8'h7e,
               8'h05, 8'h06, 8'h7e};
    send_link();
    settle();

    // Buffer limits: a payload that fills every entry and a frame that runs
    // past the end and must be dropped.
    program_regs(8'hff, 8'h00, 8'hff);
    queue_frame(FR_GOOD, Depth - 1);
    queue_frame(FR_OVERFLOW, 0);
    send_link();
    settle();

    // Random phases, each under its own register setting. The first uses the
    // opposite extremes, the second gives flag and escape the same value so
    // that the flag meaning has to win; the rest are fully random.
    sent_mark = bytes_sent;
    phase = 0;
    while ((phase < 2) || (bytes_sent - sent_mark < RandomBytes)) begin
      case (phase)
        0: begin
          f = 8'h00;
          e = 8'hff;
          m = 8'h00;
        end
        1: begin
          f = ByteW'($urandom_range(0, 255));
          e = f;
          m = ByteW'($urandom_range(0, 255));
        end
        default: begin
          f = ByteW'($urandom_range(0, 255));
          e = ByteW'($urandom_range(0, 255));
          m = ByteW'($urandom_range(0, 255));
        end
      endcase
      program_regs(f, e, m);
      rx_quiet = ($urandom_range(0, 3) == 0);
      out_quiet = ($urandom_range(0, 3) == 0);
      frames = $urandom_range(2, 5);
      repeat (frames) begin
        r = $urandom_range(0, 99);
        if (r < 68) kind = FR_GOOD;
        else if (r < 78) kind = FR_BADSUM;
        else if (r < 86) kind = FR_SHORT;
        else if (r < 88) kind = FR_OVERFLOW;
        else kind = FR_NOISE;
        queue_frame(kind, pick_len());
      end
      send_link();
      settle();
      phase++;
    end

    // Give a stray late beat a chance to show up before the verdict.
    repeat (8) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
